// ===== design/dtoa_pkg.sv =====
// ----------------------------------------------------------------------------
// dtoa_pkg
// Shared types and constants for the 16-bit to decimal ASCII converter.
// ----------------------------------------------------------------------------
package dtoa_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGITS  = 5;
  localparam int unsigned CNT_W   = $clog2(DIGITS);

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [VALUE_W-1:0] value_t;

  localparam char_t ASCII_ZERO  = 8'h30;
  localparam char_t ASCII_SPACE = 8'h20;

  // place weight of each character position, most significant first
  localparam int unsigned PLACE_WEIGHT [DIGITS] = '{10000, 1000, 100, 10, 1};

  // word handed from one digit cell to the next
  typedef struct packed {
    value_t                  rest;
    logic                    seen;
    char_t [DIGITS-1:0]      chars;
  } dtoa_word_t;

endpackage

// ===== design/dtoa_if.sv =====
// ----------------------------------------------------------------------------
// dtoa_in_if / dtoa_out_if
// Valid/ready channels for the number request and the character results.
// ----------------------------------------------------------------------------
interface dtoa_in_if;
  import dtoa_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface dtoa_out_if;
  import dtoa_pkg::*;

  logic  valid;
  logic  ready;
  char_t character;
  logic  last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== design/dtoa_cell.sv =====
// ----------------------------------------------------------------------------
// dtoa_cell
// One decimal position: peels one digit off the remainder and writes its
// character, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module dtoa_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dtoa_pkg::dtoa_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output dtoa_pkg::dtoa_word_t out_word
);
  import dtoa_pkg::*;

  localparam int unsigned WEIGHT = PLACE_WEIGHT[POS];
  localparam int unsigned EXT_W  = VALUE_W + 1;

  logic       valid_r, valid_nxt;
  dtoa_word_t word_r, word_nxt;
  logic [3:0] dig;
  logic       seen;

  // digit = number of multiples of the weight that fit; compares are parallel
  always_comb begin
    dig = '0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, in_word.rest} >= EXT_W'(k * WEIGHT)) begin
        dig = 4'(k);
      end
    end
  end

  // ones position always shows its digit
  assign seen = in_word.seen || (dig != 4'd0) || (POS == DIGITS - 1);

  always_comb begin
    word_nxt = in_word;
    word_nxt.rest = in_word.rest - VALUE_W'(dig * WEIGHT);
    word_nxt.seen = seen;
    word_nxt.chars[POS] = seen ? (ASCII_ZERO + char_t'(dig)) : ASCII_SPACE;
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== design/dtoa_ser.sv =====
// ----------------------------------------------------------------------------
// dtoa_ser
// Holds the five finished characters and sends them one per request,
// flagging the last one.
// ----------------------------------------------------------------------------
module dtoa_ser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dtoa_pkg::char_t [dtoa_pkg::DIGITS-1:0] in_chars,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dtoa_pkg::char_t             out_character,
  output logic                        out_last
);
  import dtoa_pkg::*;

  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(DIGITS - 1);

  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  char_t [DIGITS-1:0] chars_r;
  logic               take, done, load;

  assign take     = busy_r && out_ready;
  assign done     = take && (cnt_r == LAST_POS);
  // next number loads as the last character leaves
  assign in_ready = !busy_r || done;
  assign load     = in_valid && in_ready;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (take) begin
      cnt_nxt  = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars_r <= in_chars;
    end
  end

  assign out_valid     = busy_r;
  assign out_character = chars_r[cnt_r];
  assign out_last      = (cnt_r == LAST_POS);

endmodule

// ===== design/uint16_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// uint16_to_decimal_ascii_core
// Unsigned 16-bit value to five right-aligned decimal ASCII characters.
// ----------------------------------------------------------------------------
// Each request carries one 16-bit number and yields five characters, most
// significant first, with leading zeros shown as spaces (zero reads as four
// spaces and '0'); the fifth has last set. The number runs through a row of
// five digit cells, one cell per decimal place, each with its own register,
// and then into the character register of the serializer, from which the
// first character is presented. The output register sends one character per
// cycle while the receiver is ready; the cells keep taking new numbers while
// earlier characters drain.
module uint16_to_decimal_ascii_core (
  input  logic              clk,
  input  logic              rst_n,
  dtoa_in_if.sink           in_chan,
  dtoa_out_if.source        out_chan
);
  import dtoa_pkg::*;

  dtoa_word_t word  [DIGITS+1];
  logic       vld   [DIGITS+1];
  logic       rdy   [DIGITS+1];

  always_comb begin
    word[0]       = '0;
    word[0].rest  = in_chan.value;
    word[0].seen  = 1'b0;
  end
  assign vld[0]        = in_chan.valid;
  assign in_chan.ready = rdy[0];

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    dtoa_cell #(.POS(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_word   (word[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_word  (word[i+1])
    );
  end

  dtoa_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (vld[DIGITS]),
    .in_ready      (rdy[DIGITS]),
    .in_chars      (word[DIGITS].chars),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_character (out_chan.character),
    .out_last      (out_chan.last)
  );

endmodule

// ===== design/dtoa_checker.sv =====
// ----------------------------------------------------------------------------
// dtoa_checker
// Port-level checks on the character stream of the converter.
// ----------------------------------------------------------------------------
module dtoa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input dtoa_pkg::char_t   out_character,
  input logic              out_last
);
  import dtoa_pkg::*;

  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             digit_r, digit_nxt;
  logic             take;

  assign take = out_valid && out_ready;

  always_comb begin
    pos_nxt   = pos_r;
    digit_nxt = digit_r;
    if (take) begin
      if (out_last) begin
        pos_nxt   = '0;
        digit_nxt = 1'b0;
      end else begin
        pos_nxt   = pos_r + 1'b1;
        digit_nxt = digit_r || (out_character != ASCII_SPACE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      digit_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      digit_r <= digit_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("stalled character changed");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_character == ASCII_SPACE ||
                  (out_character >= ASCII_ZERO && out_character <= ASCII_ZERO + 8'd9))
    else $error("character is neither digit nor space");

  a_last_fifth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (pos_r == CNT_W'(DIGITS - 1))) &&
                  (!out_last || out_character != ASCII_SPACE))
    else $error("last flag misplaced or last character blank");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && digit_r |-> out_character != ASCII_SPACE)
    else $error("space after a leading digit");

endmodule

bind uint16_to_decimal_ascii_core dtoa_checker u_dtoa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_character (out_chan.character),
  .out_last      (out_chan.last)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives 16-bit numbers into the decimal ASCII converter and checks that each
// one comes back as five right-aligned characters with leading spaces and the
// last flag on the fifth. Directed corner values come first, then random
// numbers spread over every decimal length, with random idles on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import dtoa_pkg::*;

  typedef struct packed {
    char_t character;
    logic  last;
  } ascii_char_t;

  typedef struct {
    value_t                    value;
    bit                        typed;
    logic [CHAR_W*DIGITS-1:0]  text;
  } stim_row_t;

  localparam int unsigned RANDOM_REQUESTS = 200;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dtoa_in_if  in_chan ();
  dtoa_out_if out_chan ();

  uint16_to_decimal_ascii_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ascii_char_t pending_chars [$];
  int unsigned error_count = 0;
  bit          steady      = 1'b0;   // no idling on either side while set

  // text typed only where the rendering is obvious; others use the predictor
  stim_row_t directed_rows [20] = '{
    '{16'd0,     1'b1, "    0"},
    '{16'd65535, 1'b1, "65535"},
    '{16'd1,     1'b1, "    1"},
    '{16'd9,     1'b1, "    9"},
    '{16'd10,    1'b1, "   10"},
    '{16'd99,    1'b1, "   99"},
    '{16'd100,   1'b1, "  100"},
    '{16'd999,   1'b1, "  999"},
    '{16'd1000,  1'b1, " 1000"},
    '{16'd9999,  1'b1, " 9999"},
    '{16'd10000, 1'b1, "10000"},
    '{16'd10001, 1'b1, "10001"},
    '{16'd65534, 1'b1, "65534"},
    '{16'd32768, 1'b1, "32768"},
    '{16'd12345, 1'b1, "12345"},
    '{16'h5555,  1'b0, ""},
    '{16'hAAAA,  1'b0, ""},
    '{16'hA000,  1'b0, ""},
    '{16'd305,   1'b0, ""},
    '{16'd5006,  1'b0, ""}
  };

  always #6 clk = ~clk;

  function automatic void render_decimal(value_t v);
    int unsigned rest;
    int unsigned digit;
    bit          shown;
    ascii_char_t c;
    rest  = v;
    shown = 1'b0;
    for (int k = 0; k < DIGITS; k++) begin
      digit = rest / PLACE_WEIGHT[k];
      rest  = rest - digit * PLACE_WEIGHT[k];
      // ones place always shows, so zero reads as a single '0'
      if (digit != 0 || k == DIGITS - 1)
        shown = 1'b1;
      c.character = shown ? char_t'(ASCII_ZERO + digit) : ASCII_SPACE;
      c.last      = (k == DIGITS - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void queue_text(logic [CHAR_W*DIGITS-1:0] text);
    ascii_char_t c;
    for (int k = 0; k < DIGITS; k++) begin
      c.character = text[CHAR_W*(DIGITS-1-k) +: CHAR_W];
      c.last      = (k == DIGITS - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 6);
  endfunction

  // spread over decimal lengths so every blanking depth shows up often
  function automatic value_t random_value();
    case ($urandom_range(5))
      0:       return value_t'($urandom_range(9));
      1:       return value_t'($urandom_range(99, 10));
      2:       return value_t'($urandom_range(999, 100));
      3:       return value_t'($urandom_range(9999, 1000));
      4:       return value_t'($urandom_range(65535, 10000));
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic send_request(input value_t v, input bit typed,
                              input logic [CHAR_W*DIGITS-1:0] text);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (idle_now()) begin
        in_chan.valid = 1'b0;
        in_chan.value = value_t'($urandom);
      end else begin
        in_chan.valid = 1'b1;
        in_chan.value = v;
      end
      @(posedge clk);
      if (in_chan.valid && in_chan.ready) begin
        taken = 1'b1;
        if (typed)
          queue_text(text);
        else
          render_decimal(v);
      end
    end
  endtask

  always @(negedge clk) begin
    out_chan.ready = !idle_now();
  end

  always @(posedge clk) begin
    ascii_char_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: got %h last %b", out_chan.character, out_chan.last);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_chan.character !== want.character) begin
          $error("character mismatch: expected %h, actual %h",
                 want.character, out_chan.character);
          error_count++;
        end
        if (out_chan.last !== want.last) begin
          $error("last mismatch: expected %b, actual %b", want.last, out_chan.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    in_chan.valid  = 1'b0;
    in_chan.value  = '0;
    out_chan.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].text);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 80 && n < 140);
      if (n == 160) begin
        // let the converter drain completely before carrying on
        @(negedge clk);
        in_chan.valid = 1'b0;
        wait (pending_chars.size() == 0);
      end
      send_request(random_value(), 1'b0, '0);
    end

    @(negedge clk);
    in_chan.valid = 1'b0;
    wait (pending_chars.size() == 0);
    repeat (20) @(posedge clk);

    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dtoa_pkg.sv
design/dtoa_if.sv
design/dtoa_cell.sv
design/dtoa_ser.sv
design/uint16_to_decimal_ascii_core.sv
design/dtoa_checker.sv
sim/testbench.sv
